[sv/median_filter_3x3_core_assert.svh]
// Assertion macros shared by the median filter RTL.
`ifndef MEDIAN_FILTER_3X3_CORE_ASSERT_SVH
`define MEDIAN_FILTER_3X3_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MF3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MF3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mf3_pkg.sv]
`default_nettype none

package mf3_pkg;

  // pixel and window geometry
  localparam int PIX_W   = 8;
  localparam int WIN_N   = 9;
  localparam int WIN_MID = 4;

  // configuration register widths and reset values
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd480;

  // frame limits; row counter runs up to height + 1 while draining
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int ROW_W         = 13;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_N-1:0] win_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

[sv/mf3_ram.sv]
`default_nettype none

module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_r <= mem_r[raddr_i];
    end
  end

  assign rdata_o = rdata_r;

endmodule

`default_nettype wire

[sv/mf3_median.sv]
`default_nettype none

module mf3_median (
  input  wire mf3_pkg::win_t win_i,
  output mf3_pkg::pix_t      med_o
);

  mf3_pkg::win_t p;

  // compare-exchange: {high, low}
  function automatic logic [2*mf3_pkg::PIX_W-1:0] cx(mf3_pkg::pix_t a, mf3_pkg::pix_t b);
    cx = (a > b) ? {a, b} : {b, a};
  endfunction

  // 19-exchange median-of-9 network, result lands in the middle slot
  always_comb begin
    p = win_i;
    {p[2], p[1]} = cx(p[1], p[2]);
    {p[5], p[4]} = cx(p[4], p[5]);
    {p[8], p[7]} = cx(p[7], p[8]);
    {p[1], p[0]} = cx(p[0], p[1]);
    {p[4], p[3]} = cx(p[3], p[4]);
    {p[7], p[6]} = cx(p[6], p[7]);
    {p[2], p[1]} = cx(p[1], p[2]);
    {p[5], p[4]} = cx(p[4], p[5]);
    {p[8], p[7]} = cx(p[7], p[8]);
    {p[3], p[0]} = cx(p[0], p[3]);
    {p[8], p[5]} = cx(p[5], p[8]);
    {p[7], p[4]} = cx(p[4], p[7]);
    {p[6], p[3]} = cx(p[3], p[6]);
    {p[4], p[1]} = cx(p[1], p[4]);
    {p[5], p[2]} = cx(p[2], p[5]);
    {p[7], p[4]} = cx(p[4], p[7]);
    {p[2], p[4]} = cx(p[4], p[2]);
    {p[4], p[6]} = cx(p[6], p[4]);
    {p[2], p[4]} = cx(p[4], p[2]);
  end

  assign med_o = p[mf3_pkg::WIN_MID];

endmodule

`default_nettype wire

[sv/median_filter_3x3_core.sv]
`default_nettype none

// 3x3 median filter for 8-bit grayscale frames streamed in row-major order.
// One transfer is taken every clock; the result of the transfer that
// completes a neighborhood is registered on out_*, and in_tready drops
// only while an item with a pending result sits behind a stalled output
// register. Two line stores (one write and one registered read per cycle)
// hold the previous rows, so output trails input by one row plus one pixel:
// after the last pixel, send image_width + 1 flush transfers (in_tuser = 1)
// to drain the frame; out_tlast marks its last pixel. Border pixels pass
// through. Flushes before the frame's last pixel are dropped, and pixels
// sent while draining count as flushes. The line stores need no clearing
// after reset. Writes to the width or height register restart the frame
// and are to be made while the filter is idle.

module median_filter_3x3_core #(
  parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [mf3_pkg::PIX_W-1:0]        in_tdata,   // [7:0] pixel_in
  input  wire logic                             in_tuser,   // [0] kind (1 = flush)
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [mf3_pkg::PIX_W-1:0]        out_tdata,  // [7:0] pixel_out
  output logic                                  out_tlast,  // frame_end
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mf3_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > mf3_pkg::WIDTH_REG_W) ? WW : mf3_pkg::WIDTH_REG_W;
  localparam int RW = mf3_pkg::ROW_W;

  // configuration
  logic [mf3_pkg::WIDTH_REG_W-1:0]  width_r;
  logic [mf3_pkg::HEIGHT_REG_W-1:0] height_r;
  logic                             cfg_acc;
  logic                             cfg_restart;

  // frame position of the next item
  logic [CW-1:0] in_column_r, in_column_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;

  // item stage
  logic          s1_v_r, s1_v_nxt;
  mf3_pkg::pix_t s1_pix_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_res_r, s1_border_r, s1_last_r;
  logic          s1_go;

  // same-column bypass around the line stores
  logic          byp_hit_r, byp_hit_nxt;
  mf3_pkg::pix_t byp_up_r, byp_mid_r;

  mf3_pkg::win_t window_r, win_nxt;

  // result register
  logic          out_valid_r;
  mf3_pkg::pix_t out_data_r;
  logic          out_last_r;

  // accept-side decode
  logic [EW-1:0]           width_ext;
  logic [WW-1:0]           eff_w, col_inc;
  logic [RW-1:0]           eff_h, orow;
  logic [CW-1:0]           ocol, w_last;
  logic                    in_acc, take, draining, col_zero;
  logic                    res_ok, border, frame_last;
  mf3_pkg::pix_t           pix_val;

  // line store ports
  mf3_pkg::pix_t up_rdata, mid_rdata, col_up, col_mid, med, result;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  // only the geometry registers restart the frame
  assign cfg_restart = cfg_acc && ((cfg_index == mf3_pkg::CFG_WIDTH) ||
                                   (cfg_index == mf3_pkg::CFG_HEIGHT));

  // effective frame size: zero reads as one, large values saturate
  assign width_ext = EW'(width_r);
  assign eff_w = (width_ext == '0) ? WW'(1) :
                 (width_ext > EW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_ext);
  assign eff_h = (height_r == '0) ? RW'(1) :
                 (height_r > RW'(mf3_pkg::MAX_HEIGHT)) ? RW'(mf3_pkg::MAX_HEIGHT) :
                 height_r;
  assign w_last = CW'(eff_w - WW'(1));

  // classify the incoming item and locate the pixel it completes
  assign draining   = in_row_r >= eff_h;
  assign in_acc     = in_tvalid && in_tready;
  assign take       = in_acc && !(in_tuser && !draining);
  assign pix_val    = draining ? '0 : in_tdata;
  assign col_zero   = in_column_r == '0;
  assign res_ok     = (in_row_r != '0) && (!col_zero || in_row_r >= RW'(2));
  assign orow       = col_zero ? in_row_r - RW'(2) : in_row_r - RW'(1);
  assign ocol       = col_zero ? w_last : in_column_r - CW'(1);
  assign border     = (orow == '0) || (orow == eff_h - RW'(1)) ||
                      (ocol == '0) || (ocol == w_last);
  assign frame_last = res_ok && (orow == eff_h - RW'(1)) && (ocol == w_last);
  assign col_inc    = WW'(in_column_r) + WW'(1);

  // item stage moves on unless its result would hit a full, stalled output
  assign s1_go     = s1_v_r && (!s1_res_r || !out_valid_r || out_tready);
  assign in_tready = !s1_v_r || s1_go;
  assign s1_v_nxt  = in_tready ? take : s1_v_r;

  // position counters
  always_comb begin
    in_column_nxt = in_column_r;
    in_row_nxt    = in_row_r;
    if (cfg_restart) begin
      in_column_nxt = '0;
      in_row_nxt    = '0;
    end else if (take) begin
      if (frame_last) begin
        in_column_nxt = '0;
        in_row_nxt    = '0;
      end else if (col_inc >= eff_w) begin
        in_column_nxt = '0;
        in_row_nxt    = in_row_r + RW'(1);
      end else begin
        in_column_nxt = CW'(col_inc);
      end
    end
  end

  assign byp_hit_nxt = take && s1_go && (s1_col_r == in_column_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= mf3_pkg::WIDTH_RST;
      height_r    <= mf3_pkg::HEIGHT_RST;
      in_column_r <= '0;
      in_row_r    <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index)
          mf3_pkg::CFG_WIDTH:  width_r  <= cfg_data[mf3_pkg::WIDTH_REG_W-1:0];
          mf3_pkg::CFG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      in_column_r <= in_column_nxt;
      in_row_r    <= in_row_nxt;
      s1_v_r      <= s1_v_nxt;
      if (cfg_restart) begin
        window_r <= '0;
      end else if (s1_go) begin
        window_r <= s1_last_r ? '0 : win_nxt;
      end
      if (s1_go && s1_res_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix_r    <= pix_val;
      s1_col_r    <= in_column_r;
      s1_res_r    <= res_ok;
      s1_border_r <= border;
      s1_last_r   <= frame_last;
      byp_hit_r   <= byp_hit_nxt;
      byp_up_r    <= col_mid;
      byp_mid_r   <= s1_pix_r;
    end
    if (s1_go && s1_res_r) begin
      out_data_r <= result;
      out_last_r <= s1_last_r;
    end
  end

  // line stores: read at transfer, written back by the item stage
  mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_mf3_ram_upper (
    .clk     (clk),
    .we_i    (s1_go),
    .waddr_i (s1_col_r),
    .wdata_i (col_mid),
    .re_i    (take),
    .raddr_i (in_column_r),
    .rdata_o (up_rdata)
  );

  mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_mf3_ram_middle (
    .clk     (clk),
    .we_i    (s1_go),
    .waddr_i (s1_col_r),
    .wdata_i (s1_pix_r),
    .re_i    (take),
    .raddr_i (in_column_r),
    .rdata_o (mid_rdata)
  );

  assign col_up  = byp_hit_r ? byp_up_r  : up_rdata;
  assign col_mid = byp_hit_r ? byp_mid_r : mid_rdata;

  // shift the window one column left and insert the new column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3]     = window_r[i*3+1];
      win_nxt[i*3 + 1] = window_r[i*3+2];
    end
    win_nxt[2] = col_up;
    win_nxt[5] = col_mid;
    win_nxt[8] = s1_pix_r;
  end

  mf3_median u_mf3_median (
    .win_i (win_nxt),
    .med_o (med)
  );

  assign result = s1_border_r ? win_nxt[mf3_pkg::WIN_MID] : med;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
`include "median_filter_3x3_core_assert.svh"

  `MF3_ASSERT_NEXT(a_stall_holds_item, clk, rst_n, s1_v_r && s1_res_r && out_valid_r && !out_tready, s1_v_r && s1_res_r, "stalled item left the item stage")
  `MF3_ASSERT_NOW(a_last_restarts, clk, rst_n, s1_v_r && s1_last_r, in_column_r == '0 && in_row_r == '0, "frame end did not restart counters")
  `MF3_ASSERT_NOW(a_bypass_width_one, clk, rst_n, byp_hit_nxt, (eff_w == WW'(1)) || s1_last_r, "line store bypass hit outside width one or frame end")
  `MF3_ASSERT_NOW(a_column_in_range, clk, rst_n, 1'b1, WW'(in_column_r) < eff_w, "column counter beyond frame width")

endmodule

`default_nettype wire

[sim/median_filter_3x3_core_tb.sv]
`default_nettype none

module median_filter_3x3_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mf3_pkg::*;

  localparam int LINE_DEPTH  = MAX_WIDTH_DEF;
  localparam int DRAIN_GAP   = 8;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 800_000;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;
  // index past the last register; a write there changes nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    pix_t pix;
    logic last;
  } filt_res_t;

  typedef enum logic [1:0] {ROW_XFER, ROW_WRITE} row_op_t;
  typedef enum logic [1:0] {BY_MODEL, NO_RESULT, TYPED_RES} row_chk_t;

  typedef struct packed {
    row_op_t                 op;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic                    kind;
    logic [CFG_DATA_W-1:0]   value;
    row_chk_t                chk;
    pix_t                    res_pix;
    logic                    res_last;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [PIX_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [PIX_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // expected filtered pixels, oldest first
  filt_res_t pending_pixels[$];
  filt_res_t oldest;
  int mismatches = 0;
  int fed_items = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles;

  // shadow of the filter state
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  pix_t upper_row [LINE_DEPTH];
  pix_t middle_row [LINE_DEPTH];
  pix_t win_q [3][3];
  int col_q;
  int row_q;
  int outs_q;

  // 1x1 frames with typed results, then a 3x3 frame left to the predictor
  dir_row_t directed_rows [29] = '{
    '{ROW_WRITE, CFG_WIDTH,  KIND_PIXEL, 13'd0,   BY_MODEL,  8'h00, 1'b0},
    '{ROW_WRITE, CFG_HEIGHT, KIND_PIXEL, 13'd0,   BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_FLUSH, 13'h05A, NO_RESULT, 8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h0FF, NO_RESULT, 8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h000, NO_RESULT, 8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_FLUSH, 13'h0A5, TYPED_RES, 8'hFF, 1'b1},
    '{ROW_XFER,  CFG_WIDTH,  KIND_FLUSH, 13'h000, NO_RESULT, 8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h000, NO_RESULT, 8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_FLUSH, 13'h0FF, NO_RESULT, 8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_FLUSH, 13'h0FF, TYPED_RES, 8'h00, 1'b1},
    '{ROW_WRITE, CFG_SPARE,  KIND_PIXEL, 13'h1FFF, BY_MODEL, 8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h081, NO_RESULT, 8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_FLUSH, 13'h000, NO_RESULT, 8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_FLUSH, 13'h000, TYPED_RES, 8'h81, 1'b1},
    '{ROW_WRITE, CFG_WIDTH,  KIND_PIXEL, 13'd3,   BY_MODEL,  8'h00, 1'b0},
    '{ROW_WRITE, CFG_HEIGHT, KIND_PIXEL, 13'd3,   BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h0FF, BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h000, BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h080, BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h001, BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h07F, BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h0FE, BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h010, BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h0EF, BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h055, BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_FLUSH, 13'h000, BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_PIXEL, 13'h0AA, BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_FLUSH, 13'h000, BY_MODEL,  8'h00, 1'b0},
    '{ROW_XFER,  CFG_WIDTH,  KIND_FLUSH, 13'h000, BY_MODEL,  8'h00, 1'b0}
  };

  median_filter_3x3_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // effective geometry: zero reads as one, oversize saturates
  function automatic int eff_width();
    int w;
    w = int'(width_q);
    if (w == 0) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = int'(height_q);
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  // median by rank: the value with at most 4 below it and at least 5 up to it
  function automatic pix_t median_of(win_t px);
    int below;
    int upto;
    pix_t pick;
    pick = '0;
    for (int i = 0; i < WIN_N; i++) begin
      below = 0;
      upto = 0;
      for (int j = 0; j < WIN_N; j++) begin
        if (px[j] < px[i]) below++;
        if (px[j] <= px[i]) upto++;
      end
      if (below <= WIN_MID && upto > WIN_MID) pick = px[i];
    end
    return pick;
  endfunction

  task automatic restart_frame();
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) win_q[i][j] = '0;
    end
    col_q = 0;
    row_q = 0;
    outs_q = 0;
  endtask

  task automatic apply_geometry(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    if (idx == CFG_WIDTH) begin
      width_q = value[WIDTH_REG_W-1:0];
      restart_frame();
    end else if (idx == CFG_HEIGHT) begin
      height_q = value[HEIGHT_REG_W-1:0];
      restart_frame();
    end
  endtask

  // one accepted transfer through the shadow filter
  task automatic predict_filtered_pixel(input logic kind, input pix_t pix,
                                        output bit took, output bit has,
                                        output filt_res_t res);
    int w;
    int h;
    int c;
    int orow;
    int ocol;
    bit draining;
    bit in_frame;
    pix_t value;
    win_t flat;
    w = eff_width();
    h = eff_height();
    draining = (row_q >= h);
    took = 1'b0;
    has = 1'b0;
    res = '0;
    // early flushes are dropped without touching state
    if (kind == KIND_FLUSH && !draining) return;
    took = 1'b1;
    value = draining ? 8'h00 : pix;

    // shift the window one column and rotate the line stores
    c = col_q % LINE_DEPTH;
    for (int i = 0; i < 3; i++) begin
      win_q[i][0] = win_q[i][1];
      win_q[i][1] = win_q[i][2];
    end
    win_q[0][2] = upper_row[c];
    win_q[1][2] = middle_row[c];
    win_q[2][2] = value;
    upper_row[c] = middle_row[c];
    middle_row[c] = value;

    in_frame = (row_q >= 1) && (col_q >= 1 || row_q >= 2);
    if (col_q == 0) begin
      orow = row_q - 2;
      ocol = w - 1;
    end else begin
      orow = row_q - 1;
      ocol = col_q - 1;
    end
    col_q++;
    if (col_q >= w) begin
      col_q = 0;
      row_q++;
    end
    if (!in_frame) return;

    has = 1'b1;
    if (orow == 0 || orow == h - 1 || ocol == 0 || ocol == w - 1) begin
      res.pix = win_q[1][1];
    end else begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) flat[i*3+j] = win_q[i][j];
      end
      res.pix = median_of(flat);
    end
    if (outs_q >= w * h - 1) begin
      res.last = 1'b1;
      restart_frame();
    end else begin
      outs_q++;
    end
  endtask

  // entered and left at a falling edge
  task automatic push_item(input logic kind, input pix_t pix,
                           input row_chk_t chk = BY_MODEL,
                           input pix_t typed_pix = '0, input logic typed_last = 1'b0);
    bit took;
    bit has;
    filt_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= pix;
    do @(posedge clk); while (!in_tready);
    predict_filtered_pixel(kind, pix, took, has, res);
    if (took) fed_items++;
    case (chk)
      BY_MODEL:  if (has) pending_pixels.push_back(res);
      TYPED_RES: pending_pixels.push_back('{typed_pix, typed_last});
      default: ;
    endcase
    @(negedge clk);
  endtask

  // sender pauses, and stays idle until every result is in
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  // register writes only with the filter idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    repeat (DRAIN_GAP) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_geometry(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one frame at the current geometry; noisy frames add stray flushes
  // and a drain that may run short or long
  task automatic stream_frame(input bit noisy);
    int w;
    int n_pix;
    int n_drain;
    logic kind;
    w = eff_width();
    n_pix = w * eff_height();
    for (int p = 0; p < n_pix; p++) begin
      if (noisy && $urandom_range(19) == 0) push_item(KIND_FLUSH, rand_pixel());
      push_item(KIND_PIXEL, rand_pixel());
      if ($urandom_range(79) == 0) wait_drained();
    end
    n_drain = noisy ? $urandom_range(w + 3) : w + 1;
    for (int d = 0; d < n_drain; d++) begin
      kind = (noisy || $urandom_range(3) == 0) ? logic'($urandom_range(1)) : KIND_FLUSH;
      push_item(kind, rand_pixel());
    end
  endtask

  task automatic random_phase(input int n);
    int goal;
    logic [CFG_DATA_W-1:0] value;
    goal = fed_items + n;
    while (fed_items < goal) begin
      // new geometry now and then, mostly small frames
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0: value = '0;
          1: value = CFG_DATA_W'($urandom_range(13, 32));
          default: value = CFG_DATA_W'($urandom_range(1, 12));
        endcase
        if ($urandom_range(7) == 0) begin
          value[CFG_DATA_W-1:WIDTH_REG_W] = (CFG_DATA_W-WIDTH_REG_W)'($urandom_range(3));
        end
        write_reg(CFG_WIDTH, value);
      end
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0: value = '0;
          1: value = CFG_DATA_W'($urandom_range(9, 16));
          default: value = CFG_DATA_W'($urandom_range(1, 8));
        endcase
        write_reg(CFG_HEIGHT, value);
      end
      case ($urandom_range(9))
        0: repeat ($urandom_range(1, 16)) push_item(logic'($urandom_range(1)), rand_pixel());
        1, 2: stream_frame(1'b1);
        default: stream_frame(1'b0);
      endcase
    end
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected transfer: pixel_out %0d frame_end %0b", out_tdata, out_tlast);
        mismatches++;
      end else begin
        oldest = pending_pixels.pop_front();
        if (out_tdata !== oldest.pix) begin
          $error("pixel_out: expected %0d, actual %0d", oldest.pix, out_tdata);
          mismatches++;
        end
        if (out_tlast !== oldest.last) begin
          $error("frame_end: expected %0b, actual %0b", oldest.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    width_q = WIDTH_RST;
    height_q = HEIGHT_RST;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    restart_frame();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    send_idle_pct = 17;
    recv_idle_pct = 53;
    // reset geometry: the start of a 640-wide frame, cut off by the first write
    repeat (24) push_item(KIND_PIXEL, rand_pixel());
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_WRITE) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        push_item(directed_rows[i].kind, directed_rows[i].value[PIX_W-1:0],
                  directed_rows[i].chk, directed_rows[i].res_pix, directed_rows[i].res_last);
      end
    end
    random_phase(230);

    send_idle_pct = 53;
    recv_idle_pct = 17;
    random_phase(230);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(230);

    // saturated width: rows wrap at the full line depth, first results of row zero
    write_reg(CFG_WIDTH, 13'h1FFF);
    write_reg(CFG_HEIGHT, 13'h1FFF);
    repeat (LINE_DEPTH + 3) push_item(KIND_PIXEL, rand_pixel());

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
